// ===== rtl/chisq_pkg.sv =====
package chisq_pkg;

  localparam int unsigned SUM_BITS = 48;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_ACC
  } back_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } back_ctrl_t;

endpackage

// ===== rtl/chisq_if.sv =====
interface chisq_in_if #(
  parameter int unsigned COUNT_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] count_a;
  logic [COUNT_BITS-1:0] count_b;
  logic                  last_bin;

  modport source (output valid, output count_a, output count_b, output last_bin,
                  input ready);
  modport sink (input valid, input count_a, input count_b, input last_bin,
                output ready);
endinterface

interface chisq_out_if
  import chisq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] distance;
  logic                saturated;

  modport source (output valid, output distance, output saturated, input ready);
  modport sink (input valid, input distance, input saturated, output ready);
endinterface

// ===== rtl/chisq_front.sv =====
module chisq_front
  import chisq_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  chisq_in_if.sink                  in_bus,
  output logic                      fq_valid,
  input  logic                      fq_ready,
  output logic [2*COUNT_BITS-1:0]   fq_num,
  output logic [COUNT_BITS+2:0]     fq_den,
  output logic                      fq_last
);

  localparam int unsigned DEN_BITS = COUNT_BITS + 3;

  logic                  s1_valid_r;
  logic [COUNT_BITS-1:0] diff_r;
  logic [DEN_BITS-1:0]   den_r;
  logic                  last_r;

  logic [COUNT_BITS-1:0] diff_nxt;
  logic [COUNT_BITS:0]   sum_ab;
  logic [DEN_BITS-1:0]   den_nxt;
  logic                  take;

  assign in_bus.ready = !s1_valid_r || fq_ready;
  assign take         = in_bus.valid && in_bus.ready;

  assign diff_nxt = (in_bus.count_a >= in_bus.count_b) ? (in_bus.count_a - in_bus.count_b)
                                                       : (in_bus.count_b - in_bus.count_a);
  assign sum_ab   = {1'b0, in_bus.count_a} + {1'b0, in_bus.count_b};
  // 2(a+b)+4
  assign den_nxt  = {1'b0, sum_ab, 1'b0} + DEN_BITS'(4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      diff_r <= diff_nxt;
      den_r  <= den_nxt;
      last_r <= in_bus.last_bin;
    end
  end

  assign fq_valid = s1_valid_r;
  assign fq_num   = (2*COUNT_BITS)'(diff_r) * (2*COUNT_BITS)'(diff_r);
  assign fq_den   = den_r;
  assign fq_last  = last_r;

endmodule

// ===== rtl/chisq_queue.sv =====
module chisq_queue
  import chisq_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/chisq_back.sv =====
module chisq_back
  import chisq_pkg::*;
#(
  parameter int unsigned COUNT_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    qb_valid,
  output logic                    qb_ready,
  input  logic [2*COUNT_BITS-1:0] qb_num,
  input  logic [COUNT_BITS+2:0]   qb_den,
  input  logic                    qb_last,
  chisq_out_if.source             out_bus
);

  localparam int unsigned NUM_BITS = 2*COUNT_BITS;
  localparam int unsigned DEN_BITS = COUNT_BITS + 3;
  localparam int unsigned DIV_BITS = NUM_BITS + FRACTION_BITS;
  localparam int unsigned CNT_BITS = $clog2(DIV_BITS);

  back_state_t         state_r;
  back_state_t         state_nxt;
  back_ctrl_t          ctrl;

  logic [DIV_BITS-1:0] dvd_r;
  logic [DEN_BITS-1:0] den_r;
  logic [DEN_BITS-1:0] rem_r;
  logic [SUM_BITS-1:0] quo_r;
  logic                qovf_r;
  logic                last_r;
  logic [CNT_BITS-1:0] cnt_r;

  logic [SUM_BITS-1:0] sum_r;
  logic                sat_r;
  logic                out_valid_r;
  logic [SUM_BITS-1:0] out_distance_r;
  logic                out_saturated_r;

  logic [DEN_BITS-1:0] rem_sh;
  logic                ge;
  logic [SUM_BITS:0]   sum_ext;
  logic                ovf;
  logic [SUM_BITS-1:0] sum_new;
  logic                sat_new;
  logic                can_commit;
  logic                div_done;

  // restoring division, one quotient bit per cycle
  assign rem_sh   = {rem_r[DEN_BITS-2:0], dvd_r[DIV_BITS-1]};
  assign ge       = (rem_sh >= den_r);
  assign div_done = (cnt_r == CNT_BITS'(DIV_BITS - 1));

  assign sum_ext    = {1'b0, sum_r} + {1'b0, quo_r};
  assign ovf        = qovf_r || sum_ext[SUM_BITS];
  assign sum_new    = ovf ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
  assign sat_new    = sat_r || ovf;
  assign can_commit = !last_r || !out_valid_r || out_bus.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (qb_valid) state_nxt = BK_DIV;
      BK_DIV:  if (div_done) state_nxt = BK_ACC;
      BK_ACC:  if (can_commit) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      BK_IDLE: ctrl.load   = qb_valid;
      BK_DIV:  ctrl.step   = 1'b1;
      BK_ACC:  ctrl.commit = can_commit;
      default: ctrl = '0;
    endcase
  end

  assign qb_ready = (state_r == BK_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      sum_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.commit && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctrl.commit) begin
        if (last_r) begin
          sum_r <= '0;
          sat_r <= 1'b0;
        end else begin
          sum_r <= sum_new;
          sat_r <= sat_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dvd_r  <= {qb_num, {FRACTION_BITS{1'b0}}};
      den_r  <= qb_den;
      last_r <= qb_last;
      rem_r  <= '0;
      quo_r  <= '0;
      qovf_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.step) begin
      dvd_r  <= {dvd_r[DIV_BITS-2:0], 1'b0};
      rem_r  <= ge ? (rem_sh - den_r) : rem_sh;
      quo_r  <= {quo_r[SUM_BITS-2:0], ge};
      qovf_r <= qovf_r || quo_r[SUM_BITS-1];
      cnt_r  <= cnt_r + CNT_BITS'(1);
    end
    if (ctrl.commit && last_r) begin
      out_distance_r  <= sum_new;
      out_saturated_r <= sat_new;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.distance  = out_distance_r;
  assign out_bus.saturated = out_saturated_r;

endmodule

// ===== rtl/chi_square_histogram_distance_top.sv =====
// the bit-serial divider in the back end takes a new bin pair only after the last one is
//   accumulated; a two-entry queue decouples the front
// reset: synchronous active-low rst_n clears the running sum, the saturation flag,
//   the queue and all valid flags
module chi_square_histogram_distance_top
  import chisq_pkg::*;
#(
  parameter int unsigned COUNT_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  chisq_in_if.sink    in_bus,
  chisq_out_if.source out_bus
);

  localparam int unsigned NUM_BITS = 2*COUNT_BITS;
  localparam int unsigned DEN_BITS = COUNT_BITS + 3;
  localparam int unsigned Q_WIDTH  = NUM_BITS + DEN_BITS + 1;

  logic                fq_valid;
  logic                fq_ready;
  logic [NUM_BITS-1:0] fq_num;
  logic [DEN_BITS-1:0] fq_den;
  logic                fq_last;

  logic                qb_valid;
  logic                qb_ready;
  logic [Q_WIDTH-1:0]  qb_data;

  chisq_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .fq_valid (fq_valid),
    .fq_ready (fq_ready),
    .fq_num   (fq_num),
    .fq_den   (fq_den),
    .fq_last  (fq_last)
  );

  chisq_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  ({fq_num, fq_den, fq_last}),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  chisq_back #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qb_valid (qb_valid),
    .qb_ready (qb_ready),
    .qb_num   (qb_data[Q_WIDTH-1 -: NUM_BITS]),
    .qb_den   (qb_data[DEN_BITS:1]),
    .qb_last  (qb_data[0]),
    .out_bus  (out_bus)
  );

`ifndef SYNTHESIS
  // back end takes one queued beat at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (qb_valid && qb_ready) |=> !qb_ready)
    else $error("back end took a second beat while dividing");

  // input stalls only when the front stage holds a beat
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> fq_valid)
    else $error("input stalled with empty front stage");

  // reset leaves no result pending
  assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("result valid after reset");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb
  import chisq_pkg::*;
();

  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned RANDOM_PAIRS  = 1300;
  localparam int          CYCLE_LIMIT   = 700000;
  localparam int          DRAIN_TAIL    = 60;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

  typedef struct {
    logic [COUNT_BITS-1:0] count_a;
    logic [COUNT_BITS-1:0] count_b;
    logic                  last_bin;
    int                    gap;
    bit                    drain;
  } bin_pair_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] distance;
    logic                saturated;
  } distance_t;

  logic clk;
  logic rst_n;

  chisq_in_if #(.COUNT_BITS(COUNT_BITS)) in_bus ();
  chisq_out_if out_bus ();

  chi_square_histogram_distance_top #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  bin_pair_t           bin_queue[$];
  distance_t           distance_queue[$];
  logic [SUM_BITS-1:0] sum_acc;
  logic                clip_seen;
  logic [SUM_BITS-1:0] peak_distance;
  bin_pair_t           head_pair;
  distance_t           got_distance;
  distance_t           want_distance;
  int                  gap_cnt;
  int                  stall_cnt;
  int                  new_stall;
  int                  pairs_sent;
  int                  distances_seen;
  int                  errors;
  int                  cycles;
  int                  pushed;
  bit                  quiet_tx;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  // exact chi-square term (a-b)^2 / (2(a+b)+4), fixed point, truncated
  function automatic logic [63:0] chi_term(input logic [COUNT_BITS-1:0] a,
                                           input logic [COUNT_BITS-1:0] b);
    logic [63:0] diff;
    logic [63:0] den;
    diff = (a >= b) ? 64'(a) - 64'(b) : 64'(b) - 64'(a);
    den  = 64'd2 * (64'(a) + 64'(b)) + 64'd4;
    return ((diff * diff) << FRACTION_BITS) / den;
  endfunction

  task automatic accumulate_chi_term(input logic [COUNT_BITS-1:0] a,
                                     input logic [COUNT_BITS-1:0] b,
                                     input logic last);
    logic [63:0] term;
    distance_t   d;
    term = chi_term(a, b);
    if (term > 64'(SUM_MAX) - 64'(sum_acc)) begin
      sum_acc   = SUM_MAX;
      clip_seen = 1'b1;
    end else begin
      sum_acc = sum_acc + term[SUM_BITS-1:0];
    end
    if (last) begin
      d.distance  = sum_acc;
      d.saturated = clip_seen;
      distance_queue.push_back(d);
      sum_acc   = '0;
      clip_seen = 1'b0;
    end
  endtask

  task automatic push_pair(input logic [COUNT_BITS-1:0] a, input logic [COUNT_BITS-1:0] b,
                           input logic last, input bit drain);
    bin_pair_t p;
    p.count_a  = a;
    p.count_b  = b;
    p.last_bin = last;
    p.drain    = drain;
    if (pushed % 90 == 0)
      quiet_tx = ($urandom_range(0, 2) == 0);
    p.gap = quiet_tx ? 0 : $urandom_range(0, 11);
    bin_queue.push_back(p);
    pushed++;
  endtask

  function automatic logic [COUNT_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return COUNT_BITS'(1);
      2: return COUNT_MAX - COUNT_BITS'(1);
      default: return COUNT_MAX;
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      gap_cnt      <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        accumulate_chi_term(in_bus.count_a, in_bus.count_b, in_bus.last_bin);
        pairs_sent++;
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the beat
      end else if (bin_queue.size() == 0) begin
        in_bus.valid <= 1'b0;
      end else if (bin_queue[0].drain && distance_queue.size() != 0) begin
        in_bus.valid <= 1'b0;
      end else if (gap_cnt < bin_queue[0].gap) begin
        in_bus.valid <= 1'b0;
        gap_cnt      <= gap_cnt + 1;
      end else begin
        head_pair       = bin_queue.pop_front();
        in_bus.valid    <= 1'b1;
        in_bus.count_a  <= head_pair.count_a;
        in_bus.count_b  <= head_pair.count_b;
        in_bus.last_bin <= head_pair.last_bin;
        gap_cnt         <= 0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_cnt     <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      got_distance.distance  = out_bus.distance;
      got_distance.saturated = out_bus.saturated;
      distances_seen++;
      if (got_distance.distance > peak_distance)
        peak_distance = got_distance.distance;
      if (distance_queue.size() == 0) begin
        flag_error($sformatf("unexpected distance beat 0x%012h", got_distance.distance));
      end else begin
        want_distance = distance_queue.pop_front();
        if (got_distance.distance !== want_distance.distance)
          flag_error($sformatf("distance 0x%012h, expected 0x%012h",
                               got_distance.distance, want_distance.distance));
        if (got_distance.saturated !== want_distance.saturated)
          flag_error($sformatf("saturated %b, expected %b",
                               got_distance.saturated, want_distance.saturated));
      end
      new_stall = ((distances_seen / 12) % 3 == 2) ? 0 : $urandom_range(0, 11);
      if (new_stall == 0) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b0;
        stall_cnt     <= new_stall - 1;
      end
    end else if (!out_bus.ready) begin
      if (stall_cnt == 0) begin
        out_bus.ready <= 1'b1;
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d distances outstanding", distance_queue.size());
      $display("** chi_square_histogram_distance_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int frame_len;
    int style;
    logic [COUNT_BITS-1:0] a;
    logic [COUNT_BITS-1:0] b;

    clk             = 1'b0;
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.count_a  = '0;
    in_bus.count_b  = '0;
    in_bus.last_bin = 1'b0;
    out_bus.ready   = 1'b0;
    sum_acc         = '0;
    clip_seen       = 1'b0;
    peak_distance   = '0;
    pairs_sent      = 0;
    distances_seen  = 0;
    errors          = 0;
    cycles          = 0;
    pushed          = 0;
    quiet_tx        = 1'b0;

    // directed: zero counts, equal counts, extremes, alternating bits
    push_pair('0, '0, 1'b1, 1'b0);
    push_pair(COUNT_MAX, '0, 1'b0, 1'b0);
    push_pair('0, COUNT_MAX, 1'b0, 1'b0);
    push_pair(COUNT_MAX, COUNT_MAX, 1'b0, 1'b0);
    push_pair(COUNT_BITS'(1), '0, 1'b0, 1'b0);
    push_pair('0, COUNT_BITS'(1), 1'b0, 1'b0);
    push_pair(16'd12345, 16'd12345, 1'b1, 1'b0);
    push_pair(COUNT_MAX, COUNT_BITS'(1), 1'b1, 1'b0);
    push_pair(16'hAAAA, 16'h5555, 1'b0, 1'b0);
    push_pair(16'h5555, 16'hAAAA, 1'b1, 1'b0);
    push_pair(COUNT_MAX - COUNT_BITS'(1), COUNT_MAX, 1'b1, 1'b1);
    push_pair(COUNT_BITS'(2), '0, 1'b0, 1'b0);
    push_pair('0, '0, 1'b1, 1'b0);

    // long frame of the largest terms to push the upper sum bits
    for (int i = 0; i < 200; i++)
      push_pair(i[0] ? COUNT_MAX : '0, i[0] ? '0 : COUNT_MAX, i == 199, 1'b0);

    while (bin_queue.size() < RANDOM_PAIRS) begin
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(1, 16);
      style = $urandom_range(0, 5);
      for (int i = 0; i < frame_len; i++) begin
        case (style)
          0: begin
            a = COUNT_BITS'($urandom);
            b = COUNT_BITS'($urandom);
          end
          1: begin
            a = COUNT_BITS'($urandom_range(0, 15));
            b = COUNT_BITS'($urandom_range(0, 15));
          end
          2: begin
            a = COUNT_BITS'($urandom);
            b = a;
          end
          3: begin
            a = COUNT_BITS'($urandom);
            b = a + COUNT_BITS'($urandom_range(0, 6)) - COUNT_BITS'(3);
          end
          4: begin
            a = pick_extreme();
            b = pick_extreme();
          end
          default: begin
            a = COUNT_BITS'($urandom);
            b = '0;
            if ($urandom_range(0, 1) == 1) begin
              b = a;
              a = '0;
            end
          end
        endcase
        push_pair(a, b, i == frame_len - 1, (pushed % 250 == 0));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (bin_queue.size() != 0 || in_bus.valid) @(posedge clk);
    while (distance_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("sent %0d bin pairs, checked %0d histogram distances, peak 0x%012h",
             pairs_sent, distances_seen, peak_distance);
    $display("sender gaps and receiver stalls 0..11 cycles, with idle-free stretches");
    if (errors == 0) begin
      $display("** chi_square_histogram_distance_top: PASSED **");
    end else begin
      $display("** chi_square_histogram_distance_top: FAILED **");
    end
    $finish;
  end

endmodule
